/* sv/ckan_pkg.sv */
// Shared types and constants for the Chebyshev KAN layer forward core.
// Holds the item, result, queue and configuration structs; no dependencies.
package ckan_pkg;

  localparam int MAX_INPUTS   = 16;
  localparam int MAX_OUTPUTS  = 8;
  localparam int MAX_TERMS    = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam int FI_W   = 4;
  localparam int OS_W   = 3;
  localparam int TI_W   = 4;
  localparam int ADDR_W = FI_W + OS_W + TI_W;
  localparam int WEIGHT_DEPTH = 1 << ADDR_W;

  localparam int ACC_W = 48;
  localparam int OUT_W = 40;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] REG_TERM_COUNT   = 2'd0;
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] MINUS_ONE_Q14 = -16'sd16384;

  typedef struct packed {
    logic              func;
    logic [3:0]        feature_index;
    logic [2:0]        output_slot;
    logic [3:0]        term_index;
    logic signed [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_index;
    logic signed [39:0] out_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [4:0] term_count;
    logic [4:0] input_count;
    logic [3:0] output_count;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [FI_W-1:0]    feature_index;
    logic [OS_W-1:0]    output_slot;
    logic [TI_W-1:0]    term_index;
    logic signed [15:0] value;
    logic               last;
  } q_word_t;

endpackage

/* sv/ckan_front.sv */
// Front end: accepts items, drops samples beyond the row, clamps samples
// and tags the row-ending feature. Depends on ckan_pkg.
module ckan_front import ckan_pkg::*; (
  input  cfg_t     cfg_i,
  input  logic     start_i,
  input  logic     full_i,
  input  in_word_t in_i,
  output logic     push_o,
  output q_word_t  word_o
);

  logic [4:0] ins;
  logic [4:0] fi_ext;
  logic       in_row;

  always_comb begin
    if (cfg_i.input_count == 5'd0) begin
      ins = 5'd1;
    end else if (cfg_i.input_count > 5'(MAX_INPUTS)) begin
      ins = 5'(MAX_INPUTS);
    end else begin
      ins = cfg_i.input_count;
    end
  end

  assign fi_ext = {1'b0, in_i.feature_index};
  assign in_row = fi_ext < ins;
  assign push_o = start_i & ~full_i & ((in_i.func == FUNC_WEIGHT) | in_row);

  always_comb begin
    word_o.func          = in_i.func;
    word_o.feature_index = in_i.feature_index;
    word_o.output_slot   = in_i.output_slot;
    word_o.term_index    = in_i.term_index;
    word_o.last          = fi_ext == (ins - 5'd1);
    word_o.value         = in_i.value;
    if (in_i.func == FUNC_SAMPLE) begin
      if (in_i.value > ONE_Q14) begin
        word_o.value = ONE_Q14;
      end else if (in_i.value < MINUS_ONE_Q14) begin
        word_o.value = MINUS_ONE_Q14;
      end
    end
  end

endmodule

/* sv/ckan_queue.sv */
// Short FIFO between front and back ends.
// Depends on ckan_pkg for the entry type and depth.
module ckan_queue import ckan_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_word_t word_i,
  input  logic    pop_i,
  output q_word_t head_o,
  output logic    empty_o,
  output logic    full_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_word_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/ckan_back.sv */
// Back end: weight store, Chebyshev term recurrence, multiply-accumulate
// over outputs and emission of saturated sums. Depends on ckan_pkg.
module ckan_back import ckan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      empty_i,
  input  q_word_t   head_i,
  output logic      pop_o,
  output logic      result_strobe_o,
  output out_word_t result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_TMUL  = 3'd3;
  localparam logic [2:0] S_TUPD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic signed [15:0] mem_q [WEIGHT_DEPTH];

  logic [2:0]         state_q, state_d;
  logic [4:0]         d_q, d_d;
  logic [3:0]         o_q, o_d;
  logic [FI_W-1:0]    fi_q, fi_d;
  logic signed [15:0] x_q, x_d;
  logic               last_q, last_d;
  logic signed [15:0] tcur_q, tcur_d;
  logic signed [15:0] tprev_q, tprev_d;
  logic               v1_q, v2_q;
  logic [OS_W-1:0]    o1_q, o2_q;
  logic signed [15:0] rd_q;
  logic signed [31:0] prod_q;
  logic signed [ACC_W-1:0] acc_q [MAX_OUTPUTS];
  logic signed [ACC_W-1:0] acc_d [MAX_OUTPUTS];
  logic               strobe_q, strobe_d;
  out_word_t          out_q, out_d;

  logic [4:0]         terms;
  logic [3:0]         outs;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic               issue;
  logic signed [15:0] mul_b;
  logic signed [31:0] prod_d;
  logic [OS_W-1:0]    acc_idx;
  logic signed [ACC_W-1:0] acc_sel;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [31:0] rnd;
  logic signed [17:0] tnext;
  logic signed [15:0] tnext_clamped;
  logic signed [OUT_W-1:0] out_sat;

  always_comb begin
    if (cfg_i.term_count > 5'(MAX_TERMS)) begin
      terms = 5'(MAX_TERMS);
    end else begin
      terms = cfg_i.term_count;
    end
    if (cfg_i.output_count == 4'd0) begin
      outs = 4'd1;
    end else if (cfg_i.output_count > 4'(MAX_OUTPUTS)) begin
      outs = 4'(MAX_OUTPUTS);
    end else begin
      outs = cfg_i.output_count;
    end
  end

  assign pop_o  = (state_q == S_IDLE) & ~empty_i;
  assign mem_we = pop_o & (head_i.func == FUNC_WEIGHT);
  assign issue  = state_q == S_MAC;

  always_comb begin
    if (mem_we) begin
      mem_addr = {head_i.feature_index, head_i.output_slot, head_i.term_index};
    end else begin
      mem_addr = {fi_q, o_q[OS_W-1:0], d_q[TI_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= head_i.value;
    end
    rd_q <= mem_q[mem_addr];
  end

  assign mul_b  = (state_q == S_TMUL) ? x_q : rd_q;
  assign prod_d = tcur_q * mul_b;

  assign acc_idx = (state_q == S_EMIT) ? o_q[OS_W-1:0] : o2_q;
  assign acc_sel = acc_q[acc_idx];
  assign acc_sum = {acc_sel[ACC_W-1], acc_sel} + {{(ACC_W-31){prod_q[31]}}, prod_q};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
    if ((&acc_sel[ACC_W-1:OUT_W-1]) | ~(|acc_sel[ACC_W-1:OUT_W-1])) begin
      out_sat = acc_sel[OUT_W-1:0];
    end else begin
      out_sat = acc_sel[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  assign rnd   = prod_q + 32'sd4096;
  assign tnext = {rnd[29], rnd[29:13]} - {{2{tprev_q[15]}}, tprev_q};

  always_comb begin
    if (tnext > 18'sd16384) begin
      tnext_clamped = ONE_Q14;
    end else if (tnext < -18'sd16384) begin
      tnext_clamped = MINUS_ONE_Q14;
    end else begin
      tnext_clamped = tnext[15:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    d_d      = d_q;
    o_d      = o_q;
    fi_d     = fi_q;
    x_d      = x_q;
    last_d   = last_q;
    tcur_d   = tcur_q;
    tprev_d  = tprev_q;
    strobe_d = 1'b0;
    out_d    = out_q;
    for (int k = 0; k < MAX_OUTPUTS; k++) begin
      acc_d[k] = acc_q[k];
    end
    if (v2_q) begin
      acc_d[o2_q] = acc_sat;
    end

    unique case (state_q)
      S_IDLE: begin
        if (pop_o && head_i.func == FUNC_SAMPLE) begin
          fi_d    = head_i.feature_index;
          x_d     = head_i.value;
          last_d  = head_i.last;
          tcur_d  = ONE_Q14;
          tprev_d = '0;
          d_d     = '0;
          o_d     = '0;
          if (terms == 5'd0) begin
            state_d = head_i.last ? S_EMIT : S_IDLE;
          end else begin
            state_d = S_MAC;
          end
        end
      end
      S_MAC: begin
        if (o_q == outs - 4'd1) begin
          o_d     = '0;
          state_d = S_DRAIN;
        end else begin
          o_d = o_q + 4'd1;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          if (d_q + 5'd1 == terms) begin
            state_d = last_q ? S_EMIT : S_IDLE;
          end else if (d_q == 5'd0) begin
            tprev_d = ONE_Q14;
            tcur_d  = x_q;
            d_d     = 5'd1;
            state_d = S_MAC;
          end else begin
            state_d = S_TMUL;
          end
        end
      end
      S_TMUL: begin
        state_d = S_TUPD;
      end
      S_TUPD: begin
        tprev_d = tcur_q;
        tcur_d  = tnext_clamped;
        d_d     = d_q + 5'd1;
        state_d = S_MAC;
      end
      S_EMIT: begin
        strobe_d        = 1'b1;
        out_d.out_index = o_q[OS_W-1:0];
        out_d.out_value = out_sat;
        out_d.last      = o_q == outs - 4'd1;
        if (o_q == outs - 4'd1) begin
          o_d     = '0;
          state_d = S_IDLE;
          for (int k = 0; k < MAX_OUTPUTS; k++) begin
            acc_d[k] = '0;
          end
        end else begin
          o_d = o_q + 4'd1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    o1_q    <= o_q[OS_W-1:0];
    o2_q    <= o1_q;
    prod_q  <= prod_d;
    fi_q    <= fi_d;
    x_q     <= x_d;
    last_q  <= last_d;
    tcur_q  <= tcur_d;
    tprev_q <= tprev_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      d_q      <= '0;
      o_q      <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      d_q      <= d_d;
      o_q      <= o_d;
      v1_q     <= issue;
      v2_q     <= v1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      strobe_q <= strobe_d;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        acc_q[k] <= acc_d[k];
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = out_q;

endmodule

/* sv/chebyshev_kan_layer_forward_core.sv */
// Top level of the Chebyshev KAN layer forward core: configuration registers
// on an APB-style port, front end, queue and back end. Depends on ckan_pkg.
//
//   channel   signals                               handshake
//   items     start, busy, in_i (in_word_t)         start & !busy
//   results   result_strobe_o, result_o (out_word_t) valid while strobe is high
//   config    psel penable pwrite paddr pwdata       psel & penable & pwrite
//
// A weight word is written into the store as it is popped. A sample with T terms
// and N outputs takes, per term, N multiply issues and a pipeline drain, and a
// recurrence step (S_TMUL, S_TUPD) for each term after the second, plus
// emission of N results on the row's last feature.
// busy is high while the two-entry queue is full. Reset clears control state
// and the accumulators and sets the configuration to 4 terms, 2 inputs and
// 1 output; the weight store is undefined until written. Results cannot be stalled.
module chebyshev_kan_layer_forward_core import ckan_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_i,
  output logic        result_strobe_o,
  output out_word_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_q, cfg_d;
  logic    push;
  logic    pop;
  logic    empty;
  logic    full;
  q_word_t front_word;
  q_word_t head_word;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign busy   = full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_TERM_COUNT:   cfg_d.term_count   = pwdata[4:0];
        REG_INPUT_COUNT:  cfg_d.input_count  = pwdata[4:0];
        REG_OUTPUT_COUNT: cfg_d.output_count = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TERM_COUNT:   prdata = {27'd0, cfg_q.term_count};
      REG_INPUT_COUNT:  prdata = {27'd0, cfg_q.input_count};
      REG_OUTPUT_COUNT: prdata = {28'd0, cfg_q.output_count};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.term_count   <= 5'd4;
      cfg_q.input_count  <= 5'd2;
      cfg_q.output_count <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ckan_front u_front (
    .cfg_i   (cfg_q),
    .start_i (start),
    .full_i  (full),
    .in_i    (in_i),
    .push_o  (push),
    .word_o  (front_word)
  );

  ckan_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (front_word),
    .pop_i   (pop),
    .head_o  (head_word),
    .empty_o (empty),
    .full_o  (full)
  );

  ckan_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .head_i          (head_word),
    .pop_o           (pop),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule
